/* hw/rtl/lkdr_pkg.sv */
// ----------------------------------------------------------------------------
// lkdr_pkg
// Shared types and reset constants for the layered keypad debounce block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lkdr_pkg;

  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned NumButtons    = 4;
  localparam int unsigned NumKeys       = 3;
  localparam int unsigned NumLayers     = 2;
  localparam int unsigned CodeWidth     = 8;
  localparam int unsigned DebWidth      = 8;
  localparam int unsigned HoldWidth     = 16;
  localparam int unsigned CfgAddrWidth  = 3;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [DebWidth-1:0]  DebounceRst = 8'd20;
  localparam logic [HoldWidth-1:0] HoldRst     = 16'd2000;

  // [layer][key] reset keycodes; leftmost entry is the highest index
  localparam logic [NumLayers-1:0][NumKeys-1:0][CodeWidth-1:0] CodeRst = '{
    '{8'd40, 8'd79, 8'd81},
    '{8'd69, 8'd80, 8'd82}
  };

  typedef enum logic [CfgAddrWidth-1:0] {
    CfgDebounce = 3'd0,
    CfgHold     = 3'd1,
    CfgL0Key1   = 3'd2,
    CfgL0Key2   = 3'd3,
    CfgL0Key3   = 3'd4,
    CfgL1Key1   = 3'd5,
    CfgL1Key2   = 3'd6,
    CfgL1Key3   = 3'd7
  } cfg_idx_e;

endpackage

`default_nettype wire

/* hw/rtl/layered_keypad_debounce_report.sv */
// ----------------------------------------------------------------------------
// layered_keypad_debounce_report
// Debounced four-button keypad with a layer key, long-hold boot request and
// compacted key reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// One input transaction is one tick: active-low levels of the layer button
// (bit 0) and three keys, plus a link-ready flag. The block takes one tick per
// clock while the output side keeps up; a tick is held in the input register,
// is evaluated by a single combinational pass against the per-button state,
// and any result is registered in the output register when the tick advances.
// A tick that causes a result waits while the output register holds a result
// that has not been taken. Ticks that cause no result still update the state
// and never wait on the output side. A result appears when a debounced
// change is accepted with the link ready (report_flag) or when the
// layer key long-hold fires (boot_request). Configuration writes take effect
// at once and are meant for idle periods; there is no clearing pass.
module layered_keypad_debounce_report #(
  parameter int unsigned COUNT_WIDTH = lkdr_pkg::CountWidthDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration write port
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_addr_i,
  input  wire  [15:0] cfg_data_i,
  // input ticks
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [3:0] pin_levels, [4] link_ready, [7:5] zero
  // results
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] slot_a, [15:8] slot_b, [23:16] slot_c,
                                      // [24] active_layer, [31:25] zero
  output logic [1:0]  m_axis_tuser    // [0] report_flag, [1] boot_request
);

  localparam int unsigned NB   = lkdr_pkg::NumButtons;
  localparam int unsigned NK   = lkdr_pkg::NumKeys;
  localparam int unsigned CW   = lkdr_pkg::CodeWidth;
  localparam int unsigned CmpW = (COUNT_WIDTH > lkdr_pkg::HoldWidth) ?
                                 COUNT_WIDTH : lkdr_pkg::HoldWidth;
  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  // configuration
  logic [lkdr_pkg::DebWidth-1:0]  debounce_q;
  logic [lkdr_pkg::HoldWidth-1:0] hold_ticks_q;
  logic [lkdr_pkg::NumLayers-1:0][NK-1:0][CW-1:0] codes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= lkdr_pkg::DebounceRst;
      hold_ticks_q <= lkdr_pkg::HoldRst;
      codes_q      <= lkdr_pkg::CodeRst;
    end else if (cfg_we_i) begin
      unique case (lkdr_pkg::cfg_idx_e'(cfg_addr_i))
        lkdr_pkg::CfgDebounce: debounce_q    <= cfg_data_i[7:0];
        lkdr_pkg::CfgHold:     hold_ticks_q  <= cfg_data_i;
        lkdr_pkg::CfgL0Key1:   codes_q[0][0] <= cfg_data_i[7:0];
        lkdr_pkg::CfgL0Key2:   codes_q[0][1] <= cfg_data_i[7:0];
        lkdr_pkg::CfgL0Key3:   codes_q[0][2] <= cfg_data_i[7:0];
        lkdr_pkg::CfgL1Key1:   codes_q[1][0] <= cfg_data_i[7:0];
        lkdr_pkg::CfgL1Key2:   codes_q[1][1] <= cfg_data_i[7:0];
        lkdr_pkg::CfgL1Key3:   codes_q[1][2] <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // input register
  logic           in_valid_q;
  logic [NB-1:0]  in_pins_q;
  logic           in_link_q;
  logic           advance;
  logic           emit;

  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_pins_q <= s_axis_tdata[3:0];
      in_link_q <= s_axis_tdata[4];
    end
  end

  // debounce / layer state
  logic [NB-1:0]                   pressed_q, pressed_d;
  logic [NB-1:0][COUNT_WIDTH-1:0]  since_q, since_d;
  logic                            layer_q, layer_d;
  logic [COUNT_WIDTH-1:0]          hold_q, hold_d;
  logic                            fired_q, fired_d;

  logic [NB-1:0]                   raw;
  logic [NB-1:0]                   acc;
  logic [NB-1:0][COUNT_WIDTH-1:0]  inc;
  logic [COUNT_WIDTH-1:0]          hold_inc;
  logic                            fired_pre;
  logic                            toggle;
  logic                            boot;
  logic                            report;
  logic [NK-1:0][CW-1:0]           key_code;
  logic [CW-1:0]                   slot_a, slot_b, slot_c;

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      inc[i]       = (since_q[i] == CntMax) ? CntMax : since_q[i] + COUNT_WIDTH'(1);
      raw[i]       = ~in_pins_q[i];
      acc[i]       = (raw[i] != pressed_q[i]) && (inc[i] > COUNT_WIDTH'(debounce_q));
      pressed_d[i] = acc[i] ? raw[i] : pressed_q[i];
      since_d[i]   = acc[i] ? '0 : inc[i];
    end

    hold_inc = (hold_q == CntMax) ? CntMax : hold_q + COUNT_WIDTH'(1);
    if (acc[0] && raw[0]) begin
      hold_d    = '0;
      fired_pre = 1'b0;
    end else begin
      hold_d    = hold_inc;
      fired_pre = fired_q;
    end

    // release toggles the layer unless the long hold already fired
    toggle  = acc[0] && !raw[0] && !fired_q;
    layer_d = layer_q ^ toggle;

    boot    = pressed_d[0] && !fired_pre && (CmpW'(hold_d) >= CmpW'(hold_ticks_q));
    fired_d = fired_pre | boot;

    report = (|acc) && in_link_q;
    emit   = report || boot;

    key_code = codes_q[layer_d];

    // compact pressed keys into the slots, in key order
    slot_a = '0;
    slot_b = '0;
    slot_c = '0;
    if (report) begin
      if (pressed_d[1]) begin
        slot_a = key_code[0];
        if (pressed_d[2]) begin
          slot_b = key_code[1];
          if (pressed_d[3]) slot_c = key_code[2];
        end else if (pressed_d[3]) begin
          slot_b = key_code[2];
        end
      end else if (pressed_d[2]) begin
        slot_a = key_code[1];
        if (pressed_d[3]) slot_b = key_code[2];
      end else if (pressed_d[3]) begin
        slot_a = key_code[2];
      end
    end
  end

  assign advance = in_valid_q && (!m_axis_tvalid || m_axis_tready || !emit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= '0;
      since_q   <= '0;
      layer_q   <= 1'b0;
      hold_q    <= '0;
      fired_q   <= 1'b0;
    end else if (advance) begin
      pressed_q <= pressed_d;
      since_q   <= since_d;
      layer_q   <= layer_d;
      hold_q    <= hold_d;
      fired_q   <= fired_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      m_axis_tdata <= {7'd0, layer_d, slot_c, slot_b, slot_a};
      m_axis_tuser <= {boot, report};
    end
  end

  // a result always carries a report or a boot request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tuser[1]))
    else $error("result without report or boot flag");

  // a boot-only result carries empty slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[23:0] == 24'd0))
    else $error("boot-only result with nonzero slots");

  // a boot request sets the fired flag, so the long hold fires only once per press
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && boot) |=> fired_q)
    else $error("hold fired flag not set after boot request");

  // an accepted change of the layer button restarts its elapsed counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && acc[0]) |=> (since_q[0] == '0))
    else $error("layer button counter not cleared on accepted change");

endmodule

`default_nettype wire

/* test/layered_keypad_debounce_report_test.sv */
// ----------------------------------------------------------------------------
// layered_keypad_debounce_report_test
// Self-checking bench for the layered keypad block. A scoreboard class keeps
// its own copy of the debounce, layer and long-hold state, predicts the
// result of every accepted tick and compares each result transaction field
// by field. The stimulus runs as follows:
//   - a phase on the reset register values
//   - directed ticks that cover the key report, the layer toggle, the boot
//     request and a dropped report
//   - random press and release sequences with bounce under several settings
//   - one long hold of the layer button that fires the boot request
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module layered_keypad_debounce_report_test;

  localparam int unsigned CntW          = lkdr_pkg::CountWidthDef;
  localparam int unsigned TimeoutCycles = 1_000_000;
  localparam int unsigned RxHoldCycles  = 300;
  localparam int unsigned DrainCycles   = 6;
  localparam int unsigned LongHoldLen   = 70;

  typedef struct {
    logic [lkdr_pkg::CodeWidth-1:0] slot_a;
    logic [lkdr_pkg::CodeWidth-1:0] slot_b;
    logic [lkdr_pkg::CodeWidth-1:0] slot_c;
    logic                           layer;
    logic                           report;
    logic                           boot;
  } key_report_t;

  class keypad_report_tracker;
    logic [lkdr_pkg::DebWidth-1:0]  deb_ticks;
    logic [lkdr_pkg::HoldWidth-1:0] hold_ticks;
    logic [lkdr_pkg::CodeWidth-1:0] codes [lkdr_pkg::NumLayers][lkdr_pkg::NumKeys];
    logic                           pressed [lkdr_pkg::NumButtons];
    logic [CntW-1:0]                since [lkdr_pkg::NumButtons];
    logic                           layer;
    logic [CntW-1:0]                hold_elapsed;
    logic                           hold_fired;
    key_report_t                    awaited [$];
    int                             errors;

    function new();
      deb_ticks   = 8'd20;
      hold_ticks  = 16'd2000;
      codes[0][0] = 8'd82;
      codes[0][1] = 8'd80;
      codes[0][2] = 8'd69;
      codes[1][0] = 8'd81;
      codes[1][1] = 8'd79;
      codes[1][2] = 8'd40;
      for (int i = 0; i < lkdr_pkg::NumButtons; i++) begin
        pressed[i] = 1'b0;
        since[i]   = '0;
      end
      layer        = 1'b0;
      hold_elapsed = '0;
      hold_fired   = 1'b0;
      errors       = 0;
    endfunction

    // values wider than a register are cut to its width
    function void set_reg(lkdr_pkg::cfg_idx_e idx,
                          logic [lkdr_pkg::CfgDataWidth-1:0] value);
      int k;
      case (idx)
        lkdr_pkg::CfgDebounce: deb_ticks = value[lkdr_pkg::DebWidth-1:0];
        lkdr_pkg::CfgHold: hold_ticks = value[lkdr_pkg::HoldWidth-1:0];
        default: begin
          k = int'(idx) - int'(lkdr_pkg::CfgL0Key1);
          codes[k / lkdr_pkg::NumKeys][k % lkdr_pkg::NumKeys] =
            value[lkdr_pkg::CodeWidth-1:0];
        end
      endcase
    endfunction

    function void note_tick(logic [lkdr_pkg::NumButtons-1:0] pins, logic link);
      logic                           changed;
      logic                           boot;
      logic                           raw;
      logic                           send_keys;
      int                             n;
      logic [lkdr_pkg::CodeWidth-1:0] slots [lkdr_pkg::NumKeys];
      key_report_t                    r;
      changed = 1'b0;
      boot    = 1'b0;
      n       = 0;
      for (int i = 0; i < lkdr_pkg::NumButtons; i++) begin
        if (since[i] != '1) since[i] = since[i] + 1'b1;
      end
      if (hold_elapsed != '1) hold_elapsed = hold_elapsed + 1'b1;

      for (int i = 0; i < lkdr_pkg::NumButtons; i++) begin
        raw = ~pins[i];
        if (raw != pressed[i] && since[i] > deb_ticks) begin
          pressed[i] = raw;
          since[i]   = '0;
          changed    = 1'b1;
          if (i == 0) begin
            if (raw) begin
              hold_elapsed = '0;
              hold_fired   = 1'b0;
            end else if (!hold_fired) begin
              layer = ~layer;
            end
          end
        end
      end

      if (pressed[0] && !hold_fired && hold_elapsed >= hold_ticks) begin
        hold_fired = 1'b1;
        boot       = 1'b1;
      end

      send_keys = changed && link;
      if (!send_keys && !boot) return;

      for (int i = 0; i < lkdr_pkg::NumKeys; i++) slots[i] = '0;
      if (send_keys) begin
        for (int i = 1; i < lkdr_pkg::NumButtons; i++) begin
          if (pressed[i]) begin
            slots[n] = codes[layer][i-1];
            n++;
          end
        end
      end
      r.slot_a = slots[0];
      r.slot_b = slots[1];
      r.slot_c = slots[2];
      r.layer  = layer;
      r.report = send_keys;
      r.boot   = boot;
      awaited.push_back(r);
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(logic [31:0] data, logic [1:0] user);
      key_report_t r;
      if (awaited.size() == 0) begin
        $error("unexpected result transaction: tdata %h tuser %b", data, user);
        errors++;
        return;
      end
      r = awaited.pop_front();
      cmp_field("slot_a", r.slot_a, data[7:0]);
      cmp_field("slot_b", r.slot_b, data[15:8]);
      cmp_field("slot_c", r.slot_c, data[23:16]);
      cmp_field("active_layer", 8'(r.layer), 8'(data[24]));
      cmp_field("report_flag", 8'(r.report), 8'(user[0]));
      cmp_field("boot_request", 8'(r.boot), 8'(user[1]));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_addr_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  keypad_report_tracker sb = new();
  bit          no_idle     = 1'b0;
  bit          rx_hold_req = 1'b0;
  int unsigned cycle_count = 0;

  layered_keypad_debounce_report dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TimeoutCycles) begin
      $display("layered_keypad_debounce_report_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready) sb.check_report(m_axis_tdata, m_axis_tuser);
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic pick_link();
    return $urandom_range(0, 99) < 85;
  endfunction

  // result side: random ready pattern, plus one long hold-off on request
  initial begin
    int run_left;
    int stall_left;
    int hold_left;
    run_left   = 0;
    stall_left = 0;
    hold_left  = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req && hold_left == 0) begin
        rx_hold_req = 1'b0;
        hold_left   = RxHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (no_idle) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        m_axis_tready <= 1'b1;
      end else begin
        run_left   = $urandom_range(1, 20);
        stall_left = pick_gap();
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_tick(logic [3:0] pins, logic link);
    int gap;
    s_axis_tdata  <= {3'b000, link, pins};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(pins, link);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // ticks with no result may still be in flight, hence the extra cycles
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(lkdr_pkg::cfg_idx_e idx, logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.set_reg(idx, value);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic randomize_cfg(int deb_hi, int hold_lo, int hold_hi);
    write_cfg(lkdr_pkg::CfgDebounce, {8'($urandom), 8'($urandom_range(0, deb_hi))});
    write_cfg(lkdr_pkg::CfgHold, 16'($urandom_range(hold_lo, hold_hi)));
    for (int k = 0; k < lkdr_pkg::NumLayers * lkdr_pkg::NumKeys; k++) begin
      write_cfg(lkdr_pkg::cfg_idx_e'(int'(lkdr_pkg::CfgL0Key1) + k), 16'($urandom));
    end
  endtask

  // press/release patterns: optional bounce, then a steady level whose length
  // is mostly around the debounce window
  task automatic run_segments(int n_items);
    int         sent;
    int         len;
    int         bounce;
    int         r;
    logic [3:0] target;
    sent = 0;
    while (sent < n_items) begin
      target = 4'($urandom);
      bounce = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 3) : 0;
      repeat (bounce) send_tick(4'($urandom), pick_link());
      r = $urandom_range(0, 9);
      if (r < 6) len = $urandom_range(1, int'(sb.deb_ticks) + 2);
      else if (r < 9) len = $urandom_range(1, 4);
      else len = int'(sb.deb_ticks) + $urandom_range(5, 30);
      repeat (len) send_tick(target, pick_link());
      sent += bounce + len;
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= lkdr_pkg::CfgDebounce;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values
    run_segments(60);
    wait_idle();

    // directed: no debounce, short hold, extreme codes, upper bits masked
    write_cfg(lkdr_pkg::CfgDebounce, 16'hFF00);
    write_cfg(lkdr_pkg::CfgHold, 16'h0003);
    write_cfg(lkdr_pkg::CfgL0Key1, 16'hA5FF);
    write_cfg(lkdr_pkg::CfgL0Key2, 16'h7F00);
    write_cfg(lkdr_pkg::CfgL0Key3, 16'h0001);
    write_cfg(lkdr_pkg::CfgL1Key1, 16'hFF80);
    write_cfg(lkdr_pkg::CfgL1Key2, 16'h0155);
    write_cfg(lkdr_pkg::CfgL1Key3, 16'h00AA);
    send_tick(4'hF, 1'b1);            // all buttons released
    send_tick(4'hD, 1'b1);            // key one
    send_tick(4'h1, 1'b1);            // all three keys
    send_tick(4'h1, 1'b0);
    send_tick(4'hF, 1'b0);            // accepted release, report dropped
    repeat (5) send_tick(4'hE, 1'b1); // layer press, then boot without report
    send_tick(4'hF, 1'b1);            // release after boot: layer stays
    send_tick(4'hE, 1'b0);
    send_tick(4'hF, 1'b1);            // short press: the layer toggles
    send_tick(4'h9, 1'b1);
    send_tick(4'hB, 1'b1);            // compaction into the first slot
    repeat (4) send_tick(4'h0, 1'b1);
    wait_idle();

    // hold threshold zero: report and boot on the same tick
    write_cfg(lkdr_pkg::CfgHold, 16'h0000);
    write_cfg(lkdr_pkg::CfgDebounce, 16'h0002);
    send_tick(4'hF, 1'b1);
    repeat (3) send_tick(4'hE, 1'b1); // bounce window rejects the first two
    send_tick(4'h6, 1'b1);
    wait_idle();

    // dense results, with a long receiver hold-off that backs up the input
    randomize_cfg(0, 1, 6);
    run_segments(40);
    rx_hold_req = 1'b1;
    run_segments(60);
    wait_idle();

    // stretch with no idling on either side
    randomize_cfg(3, 0, 10);
    no_idle = 1'b1;
    run_segments(80);
    no_idle = 1'b0;

    repeat (4) begin
      wait_idle();
      randomize_cfg(12, 0, 40);
      run_segments(70);
    end
    wait_idle();

    // long layer-button hold that fires the boot request; upper bits masked
    write_cfg(lkdr_pkg::CfgDebounce, 16'h5A06);
    write_cfg(lkdr_pkg::CfgHold, 16'd48);
    no_idle = 1'b1;
    repeat (10) send_tick(4'hF, pick_link());
    repeat (LongHoldLen) send_tick(4'hE, 1'b1);
    no_idle = 1'b0;
    send_tick(4'hC, 1'b1);
    run_segments(20);
    wait_idle();

    if (sb.errors == 0) begin
      $display("layered_keypad_debounce_report_test OK");
    end else begin
      $display("layered_keypad_debounce_report_test NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/lkdr_pkg.sv
hw/rtl/layered_keypad_debounce_report.sv
test/layered_keypad_debounce_report_test.sv
